### rtl/ilb_pkg.sv
package ilb_pkg;

   localparam int CAPACITY = 64;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 7;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 4;

   // request word: op, position, data_in; result word: ok, data_out,
   // length, is_empty, front_value, back_value
   localparam int REQ_BITS    = OP_W + POS_W + DATA_W;
   localparam int RSP_BITS    = 1 + DATA_W + CNT_W + 1 + DATA_W + DATA_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd2;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd3;
   localparam logic [OP_W-1:0] OP_INSERT     = 4'd4;
   localparam logic [OP_W-1:0] OP_REMOVE     = 4'd5;
   localparam logic [OP_W-1:0] OP_GET        = 4'd6;
   localparam logic [OP_W-1:0] OP_SET        = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

   // slot read address select
   localparam logic [2:0] RD_TARGET = 3'd0;
   localparam logic [2:0] RD_BELOW  = 3'd1;
   localparam logic [2:0] RD_ABOVE  = 3'd2;
   localparam logic [2:0] RD_FIRST  = 3'd3;
   localparam logic [2:0] RD_LAST   = 3'd4;

   // slot write select
   localparam logic WR_SHIFT = 1'b0;
   localparam logic WR_INPUT = 1'b1;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      logic [2:0] rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       idx_load_count;
      logic       idx_load_target;
      logic       idx_dec;
      logic       idx_inc;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       cnt_clr;
      logic       dout_load;
      logic       front_load;
      logic       back_load;
      logic       result_load;
      logic       ok;
   } cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            target_le_count;
      logic            target_lt_count;
      logic            idx_gt_target;
      logic            idx_next_lt_count;
      logic            out_free;
   } sts_type;

endpackage

### rtl/indexed_list_buffer_core.sv
// Channel   Direction  Ports                      Payload
// request   in         req_tvalid/tready/tdata    op, position, data_in
// response  out        rsp_tvalid/tready/tdata    ok, data_out, length, is_empty,
//                                                 front_value, back_value
//
// One request at a time; a single-port slot memory (one read, one write per
// cycle) sets the pace: each entry moved by the shift takes one read and
// one write, and front and back are read again after an insert, remove or set.
// Reset (synchronous) empties the list; slot contents need no clearing.
// A finished response waits in the output register; the next request is
// taken while it waits, and a stalled rsp_tready holds the engine only at
// its final step.
module indexed_list_buffer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [3:0] op, [10:4] position, [42:11] data_in, upper bits zero
   input  logic [ilb_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [0] ok, [32:1] data_out, [39:33] length, [40] is_empty,
   // [72:41] front_value, [104:73] back_value, upper bits zero
   output logic [ilb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int POS_LO  = ilb_pkg::OP_W;
   localparam int DIN_LO  = POS_LO + ilb_pkg::POS_W;

   ilb_pkg::cmd_type cmd;
   ilb_pkg::sts_type sts;

   logic                          rsp_ok;
   logic [ilb_pkg::DATA_W-1:0]    rsp_data_out;
   logic [ilb_pkg::CNT_W-1:0]     rsp_length;
   logic                          rsp_is_empty;
   logic [ilb_pkg::DATA_W-1:0]    rsp_front_value;
   logic [ilb_pkg::DATA_W-1:0]    rsp_back_value;

   // sequence each request: decode, shift loop, front/back refresh, respond
   ilb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // slot memory, count, cached ends and the response register
   ilb_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_op          (req_tdata[POS_LO-1:0]),
      .req_position    (req_tdata[DIN_LO-1:POS_LO]),
      .req_data_in     (req_tdata[DIN_LO+ilb_pkg::DATA_W-1:DIN_LO]),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_ok          (rsp_ok),
      .rsp_data_out    (rsp_data_out),
      .rsp_length      (rsp_length),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value)
   );

   // pack the response word, first field lowest
   assign rsp_tdata = ilb_pkg::RSP_TDATA_W'({rsp_back_value, rsp_front_value, rsp_is_empty,
                                             rsp_length, rsp_data_out, rsp_ok});

endmodule

### rtl/ilb_ctrl.sv
module ilb_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ilb_pkg::sts_type sts,
   output ilb_pkg::cmd_type cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_DECODE  = 4'd1;
   localparam logic [3:0] S_INS_CHK = 4'd2;
   localparam logic [3:0] S_INS_WR  = 4'd3;
   localparam logic [3:0] S_RM_CAP  = 4'd4;
   localparam logic [3:0] S_RM_CHK  = 4'd5;
   localparam logic [3:0] S_RM_WR   = 4'd6;
   localparam logic [3:0] S_GET_CAP = 4'd7;
   localparam logic [3:0] S_REF0    = 4'd8;
   localparam logic [3:0] S_REF1    = 4'd9;
   localparam logic [3:0] S_REF2    = 4'd10;
   localparam logic [3:0] S_RESULT  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       ok_ff, ok_in;

   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in = state_ff;
      ok_in    = ok_ff;
      cmd      = '0;
      cmd.ok   = ok_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            ok_in    = 1'b0;
            state_in = S_RESULT;
            case (sts.op)
               ilb_pkg::OP_PUSH_FRONT, ilb_pkg::OP_PUSH_BACK, ilb_pkg::OP_INSERT: begin
                  if (!sts.full && sts.target_le_count) begin
                     ok_in              = 1'b1;
                     cmd.idx_load_count = 1'b1;
                     state_in           = S_INS_CHK;
                  end
               end
               ilb_pkg::OP_POP_FRONT, ilb_pkg::OP_POP_BACK, ilb_pkg::OP_REMOVE: begin
                  if (sts.target_lt_count) begin
                     ok_in               = 1'b1;
                     cmd.rd_en           = 1'b1;
                     cmd.rd_sel          = ilb_pkg::RD_TARGET;
                     cmd.idx_load_target = 1'b1;
                     state_in            = S_RM_CAP;
                  end
               end
               ilb_pkg::OP_GET: begin
                  if (sts.target_lt_count) begin
                     ok_in      = 1'b1;
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = ilb_pkg::RD_TARGET;
                     state_in   = S_GET_CAP;
                  end
               end
               ilb_pkg::OP_SET: begin
                  if (sts.target_lt_count) begin
                     ok_in      = 1'b1;
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = ilb_pkg::WR_INPUT;
                     state_in   = S_REF0;
                  end
               end
               ilb_pkg::OP_CLEAR: begin
                  ok_in       = 1'b1;
                  cmd.cnt_clr = 1'b1;
               end
               default: begin
                  ok_in = 1'b0;
               end
            endcase
         end
         S_INS_CHK: begin
            if (sts.idx_gt_target) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ilb_pkg::RD_BELOW;
               state_in   = S_INS_WR;
            end else begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = ilb_pkg::WR_INPUT;
               cmd.cnt_inc = 1'b1;
               state_in    = S_REF0;
            end
         end
         S_INS_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = ilb_pkg::WR_SHIFT;
            cmd.idx_dec = 1'b1;
            state_in    = S_INS_CHK;
         end
         S_RM_CAP: begin
            cmd.dout_load = 1'b1;
            state_in      = S_RM_CHK;
         end
         S_RM_CHK: begin
            if (sts.idx_next_lt_count) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = ilb_pkg::RD_ABOVE;
               state_in   = S_RM_WR;
            end else begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_REF0;
            end
         end
         S_RM_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = ilb_pkg::WR_SHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = S_RM_CHK;
         end
         S_GET_CAP: begin
            cmd.dout_load = 1'b1;
            state_in      = S_RESULT;
         end
         S_REF0: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = ilb_pkg::RD_FIRST;
            state_in   = S_REF1;
         end
         S_REF1: begin
            cmd.front_load = 1'b1;
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = ilb_pkg::RD_LAST;
            state_in       = S_REF2;
         end
         S_REF2: begin
            cmd.back_load = 1'b1;
            state_in      = S_RESULT;
         end
         S_RESULT: begin
            if (sts.out_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ok_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ok_ff    <= ok_in;
      end
   end

endmodule

### rtl/ilb_datapath.sv
module ilb_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  ilb_pkg::cmd_type                 cmd,
   output ilb_pkg::sts_type                 sts,
   input  logic [ilb_pkg::OP_W-1:0]         req_op,
   input  logic [ilb_pkg::POS_W-1:0]        req_position,
   input  logic [ilb_pkg::DATA_W-1:0]       req_data_in,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic [ilb_pkg::DATA_W-1:0]       rsp_data_out,
   output logic [ilb_pkg::CNT_W-1:0]        rsp_length,
   output logic                             rsp_is_empty,
   output logic [ilb_pkg::DATA_W-1:0]       rsp_front_value,
   output logic [ilb_pkg::DATA_W-1:0]       rsp_back_value
);

   logic [ilb_pkg::DATA_W-1:0] slots [ilb_pkg::CAPACITY];

   logic [ilb_pkg::OP_W-1:0]   op_ff;
   logic [ilb_pkg::POS_W-1:0]  pos_ff;
   logic [ilb_pkg::DATA_W-1:0] din_ff;
   logic [ilb_pkg::DATA_W-1:0] dout_ff;
   logic [ilb_pkg::DATA_W-1:0] rdata_ff;
   logic [ilb_pkg::DATA_W-1:0] front_ff;
   logic [ilb_pkg::DATA_W-1:0] back_ff;
   logic [ilb_pkg::CNT_W-1:0]  count_ff;
   logic [ilb_pkg::CNT_W-1:0]  idx_ff;
   logic                       rsp_valid_ff;

   logic [ilb_pkg::CNT_W-1:0]  target;
   logic [ilb_pkg::CNT_W-1:0]  count_m1;
   logic [ilb_pkg::CNT_W:0]    idx_p1;
   logic [ilb_pkg::CNT_W-1:0]  rd_pos;
   logic [ilb_pkg::CNT_W-1:0]  wr_pos;
   logic [ilb_pkg::DATA_W-1:0] wr_data;
   logic                       empty;

   assign count_m1 = count_ff - 1'b1;
   assign idx_p1   = {1'b0, idx_ff} + 1'b1;
   assign empty    = (count_ff == '0);

   // element index the request works on
   always_comb begin
      case (op_ff)
         ilb_pkg::OP_PUSH_FRONT, ilb_pkg::OP_POP_FRONT: target = '0;
         ilb_pkg::OP_PUSH_BACK:                         target = count_ff;
         ilb_pkg::OP_POP_BACK:                          target = count_m1;
         default:                                       target = pos_ff;
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         ilb_pkg::RD_BELOW: rd_pos = idx_ff - 1'b1;
         ilb_pkg::RD_ABOVE: rd_pos = idx_p1[ilb_pkg::CNT_W-1:0];
         ilb_pkg::RD_FIRST: rd_pos = '0;
         ilb_pkg::RD_LAST:  rd_pos = count_m1;
         default:           rd_pos = target;
      endcase
   end

   assign wr_pos  = (cmd.wr_sel == ilb_pkg::WR_INPUT) ? target : idx_ff;
   assign wr_data = (cmd.wr_sel == ilb_pkg::WR_INPUT) ? din_ff : rdata_ff;

   always_comb begin
      sts.op                = op_ff;
      sts.full              = (count_ff == ilb_pkg::CNT_W'(ilb_pkg::CAPACITY));
      sts.target_le_count   = (target <= count_ff);
      sts.target_lt_count   = (target < count_ff);
      sts.idx_gt_target     = (idx_ff > target);
      sts.idx_next_lt_count = (idx_p1 < {1'b0, count_ff});
      sts.out_free          = !rsp_valid_ff || rsp_ready;
   end

   // slot store: one read, one write a cycle, registered read
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= slots[rd_pos[ilb_pkg::ADDR_W-1:0]];
      end
      if (cmd.wr_en) begin
         slots[wr_pos[ilb_pkg::ADDR_W-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_op;
         pos_ff  <= req_position;
         din_ff  <= req_data_in;
         dout_ff <= '0;
      end else if (cmd.dout_load) begin
         dout_ff <= rdata_ff;
      end
      if (cmd.idx_load_count) begin
         idx_ff <= count_ff;
      end else if (cmd.idx_load_target) begin
         idx_ff <= target;
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - 1'b1;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_p1[ilb_pkg::CNT_W-1:0];
      end
      if (cmd.front_load) begin
         front_ff <= rdata_ff;
      end
      if (cmd.back_load) begin
         back_ff <= rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.cnt_clr) begin
         count_ff <= '0;
      end else if (cmd.cnt_inc) begin
         count_ff <= count_ff + 1'b1;
      end else if (cmd.cnt_dec) begin
         count_ff <= count_m1;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         rsp_ok          <= cmd.ok;
         rsp_data_out    <= dout_ff;
         rsp_length      <= count_ff;
         rsp_is_empty    <= empty;
         rsp_front_value <= empty ? '0 : front_ff;
         rsp_back_value  <= empty ? '0 : back_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
